>>> sv/irs_pkg.sv
// Shared types and codes for the idempotent result store.
`timescale 1ns / 1ps

package irs_pkg;

    typedef enum logic [1:0] {
        CMD_INSPECT = 2'd0,
        CMD_RETAIN  = 2'd1,
        CMD_MARK    = 2'd2,
        CMD_EVICT   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        DEC_AVAILABLE  = 3'd0,
        DEC_REPLAY     = 3'd1,
        DEC_CONFLICT   = 3'd2,
        DEC_OVERLOADED = 3'd3,
        DEC_SCOPE      = 3'd4
    } t_dec;

    typedef enum logic [1:0] {
        CFG_SESSION    = 2'd0,
        CFG_GENERATION = 2'd1,
        CFG_BATTLE     = 2'd2,
        CFG_RETENTION  = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    typedef struct packed {
        logic [31:0] key;
        logic [31:0] hint;
        logic [31:0] data;
    } t_entry;

endpackage

>>> sv/irs_entry_ram.sv
// Entry memory: one write port, one registered read port.
`timescale 1ns / 1ps

module irs_entry_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [AW-1:0]        i_waddr,
    input  irs_pkg::t_entry      i_wdata,
    input  logic [AW-1:0]        i_raddr,
    output irs_pkg::t_entry      o_rdata
);

    irs_pkg::t_entry r_mem [0:DEPTH-1];
    irs_pkg::t_entry r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule

>>> sv/idempotent_result_store_unit.sv
// Top level of the idempotent result store: scope check, entry scan, retain, mark, evict.
//
// One item is handled at a time. Mark completed, evict and any item whose scope
// does not match go from acceptance through the done state into the output
// register, which they enter once the previous result has been collected. Inspect
// and retain scan the stored entries through the single read port of the entry
// memory, one entry per cycle in a pipelined walk, stopping at the first key
// match. A new item is taken as soon as the previous one has moved to the output
// register, even if that result has not yet been collected.
`timescale 1ns / 1ps

module idempotent_result_store_unit #(
    parameter int CAPACITY = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,

    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_command,
    input  logic [31:0] i_req_session,
    input  logic [31:0] i_req_generation,
    input  logic [31:0] i_req_battle,
    input  logic [31:0] i_request_id,
    input  logic [31:0] i_target_hint,
    input  logic [31:0] i_result_request_id,
    input  logic [31:0] i_result_battle,
    input  logic [31:0] i_result_payload,
    input  logic [63:0] i_time_now,

    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_decision,
    output logic        o_stored,
    output logic [31:0] o_replay_payload,
    output logic [4:0]  o_removed_count
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic [31:0] r_session_scope;
    logic [31:0] r_generation_scope;
    logic [31:0] r_battle_scope;
    logic [63:0] r_retention;

    irs_pkg::t_state r_state, n_state;
    irs_pkg::t_cmd   r_cmd, n_cmd;
    irs_pkg::t_dec   r_dec, n_dec;
    logic [31:0]     r_key, n_key;
    logic [31:0]     r_hint, n_hint;
    logic [31:0]     r_data, n_data;
    logic [63:0]     r_time, n_time;
    logic            r_ids_ok, n_ids_ok;
    logic [31:0]     r_pay, n_pay;
    logic [CW-1:0]   r_issue, n_issue;
    logic            r_rd_vld, n_rd_vld;
    logic [CW-1:0]   r_count, n_count;
    logic            r_cmpl, n_cmpl;
    logic [63:0]     r_cmpl_time, n_cmpl_time;

    logic            r_o_valid, n_o_valid;
    irs_pkg::t_dec   r_o_dec, n_o_dec;
    logic            r_o_stored, n_o_stored;
    logic [31:0]     r_o_pay, n_o_pay;
    logic [4:0]      r_o_rem, n_o_rem;

    logic            scope_ok;
    logic            issue_ok;
    logic            full;
    logic            ram_we;
    irs_pkg::t_entry ram_wdata;
    irs_pkg::t_entry ram_q;

    irs_entry_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (ram_wdata),
        .i_raddr (r_issue[AW-1:0]),
        .o_rdata (ram_q)
    );

    assign ram_wdata = '{key: r_key, hint: r_hint, data: r_data};
    assign scope_ok  = (i_req_session == r_session_scope)
                    && (i_req_generation == r_generation_scope)
                    && (i_req_battle == r_battle_scope);
    assign issue_ok  = r_issue < r_count;
    assign full      = r_count >= CW'(CAPACITY);

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_dec       = r_dec;
        n_key       = r_key;
        n_hint      = r_hint;
        n_data      = r_data;
        n_time      = r_time;
        n_ids_ok    = r_ids_ok;
        n_pay       = r_pay;
        n_issue     = r_issue;
        n_rd_vld    = 1'b0;
        n_count     = r_count;
        n_cmpl      = r_cmpl;
        n_cmpl_time = r_cmpl_time;
        n_o_valid   = r_o_valid;
        n_o_dec     = r_o_dec;
        n_o_stored  = r_o_stored;
        n_o_pay     = r_o_pay;
        n_o_rem     = r_o_rem;
        ram_we      = 1'b0;

        if (r_o_valid && i_ready) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            irs_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_cmd    = irs_pkg::t_cmd'(i_command);
                    n_key    = i_request_id;
                    n_hint   = i_target_hint;
                    n_data   = i_result_payload;
                    n_time   = i_time_now;
                    n_ids_ok = (i_result_request_id == i_request_id)
                            && (i_result_battle == i_req_battle);
                    n_pay    = '0;
                    n_issue  = '0;
                    n_rd_vld = 1'b0;
                    n_dec    = irs_pkg::DEC_AVAILABLE;
                    if (irs_pkg::t_cmd'(i_command) inside {irs_pkg::CMD_INSPECT,
                                                           irs_pkg::CMD_RETAIN}) begin
                        if (scope_ok) begin
                            n_state = irs_pkg::ST_SCAN;
                        end else begin
                            n_dec   = irs_pkg::DEC_SCOPE;
                            n_state = irs_pkg::ST_DONE;
                        end
                    end else begin
                        n_state = irs_pkg::ST_DONE;
                    end
                end
            end
            irs_pkg::ST_SCAN: begin
                n_rd_vld = issue_ok;
                if (issue_ok) begin
                    n_issue = r_issue + 1'b1;
                end
                if (r_rd_vld && (ram_q.key == r_key)) begin
                    if (ram_q.hint == r_hint) begin
                        n_dec = irs_pkg::DEC_REPLAY;
                        n_pay = ram_q.data;
                    end else begin
                        n_dec = irs_pkg::DEC_CONFLICT;
                    end
                    n_state = irs_pkg::ST_DONE;
                end else if (!r_rd_vld && !issue_ok) begin
                    n_dec   = full ? irs_pkg::DEC_OVERLOADED : irs_pkg::DEC_AVAILABLE;
                    n_state = irs_pkg::ST_DONE;
                end
            end
            irs_pkg::ST_DONE: begin
                if (!r_o_valid || i_ready) begin
                    n_o_valid  = 1'b1;
                    n_o_dec    = r_dec;
                    n_o_stored = 1'b0;
                    n_o_pay    = r_pay;
                    n_o_rem    = '0;
                    n_state    = irs_pkg::ST_IDLE;
                    case (r_cmd)
                        irs_pkg::CMD_RETAIN: begin
                            if (r_dec == irs_pkg::DEC_AVAILABLE && r_ids_ok && !full) begin
                                ram_we     = 1'b1;
                                n_count    = r_count + 1'b1;
                                n_o_stored = 1'b1;
                            end
                        end
                        irs_pkg::CMD_MARK: begin
                            if (!r_cmpl) begin
                                n_cmpl      = 1'b1;
                                n_cmpl_time = r_time;
                            end
                        end
                        irs_pkg::CMD_EVICT: begin
                            if (r_cmpl && (r_time >= r_cmpl_time)
                                && ((r_time - r_cmpl_time) >= r_retention)) begin
                                n_o_rem = 5'(r_count);
                                n_count = '0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
                n_state = irs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_session_scope    <= '0;
            r_generation_scope <= '0;
            r_battle_scope     <= '0;
            r_retention        <= '0;
            r_state            <= irs_pkg::ST_IDLE;
            r_rd_vld           <= 1'b0;
            r_count            <= '0;
            r_cmpl             <= 1'b0;
            r_cmpl_time        <= '0;
            r_o_valid          <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (irs_pkg::t_cfg_idx'(i_cfg_index))
                    irs_pkg::CFG_SESSION:    r_session_scope    <= i_cfg_data[31:0];
                    irs_pkg::CFG_GENERATION: r_generation_scope <= i_cfg_data[31:0];
                    irs_pkg::CFG_BATTLE:     r_battle_scope     <= i_cfg_data[31:0];
                    irs_pkg::CFG_RETENTION:  r_retention        <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            r_state     <= n_state;
            r_rd_vld    <= n_rd_vld;
            r_count     <= n_count;
            r_cmpl      <= n_cmpl;
            r_cmpl_time <= n_cmpl_time;
            r_o_valid   <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_dec      <= n_dec;
        r_key      <= n_key;
        r_hint     <= n_hint;
        r_data     <= n_data;
        r_time     <= n_time;
        r_ids_ok   <= n_ids_ok;
        r_pay      <= n_pay;
        r_issue    <= n_issue;
        r_o_dec    <= n_o_dec;
        r_o_stored <= n_o_stored;
        r_o_pay    <= n_o_pay;
        r_o_rem    <= n_o_rem;
    end

    assign o_cfg_ready      = 1'b1;
    assign o_ready          = (r_state == irs_pkg::ST_IDLE);
    assign o_valid          = r_o_valid;
    assign o_decision       = r_o_dec;
    assign o_stored         = r_o_stored;
    assign o_replay_payload = r_o_pay;
    assign o_removed_count  = r_o_rem;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count beyond capacity");

    a_store_only_available: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_stored) |-> (r_o_dec == irs_pkg::DEC_AVAILABLE))
        else $error("entry stored with a decision other than available");

    a_removed_only_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && (r_o_rem != '0)) |->
            (r_o_dec == irs_pkg::DEC_AVAILABLE && !r_o_stored && r_o_pay == '0))
        else $error("removed count on a non-evict result");

    a_read_from_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> $past(r_state == irs_pkg::ST_SCAN))
        else $error("entry read outside scan");

endmodule
